FILE: hw/rtl/drt_pkg.sv
`default_nettype none

package drt_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_MARK  = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_FLUSH = 2'd3
    } t_kind;

    // Input word
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic       full_frame;
        logic       region_valid;
        logic [8:0] out_left;
        logic [7:0] out_top;
        logic [8:0] out_width;
        logic [7:0] out_height;
        logic       pending;
        logic       last;
    } t_out_word;

    // Width of the clamp arithmetic, wide enough for the sum of an edge and a width
    localparam int CLAMP_W = 19;

endpackage

`default_nettype wire

FILE: hw/rtl/drt_ram.sv
`default_nettype none

module drt_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, registered read port that holds between reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dirty_region_tracker.sv
// Mark region: the item passes through the clamp, mark and reply states, then back to idle.
// Mark full frame / clear: the item goes straight to the reply state, then back to idle.
// Flush: each stored region takes a list memory read state, then an output register load state.
// A full-frame or empty flush answers with one result word from its own state, then back to idle.
// Reset (i_rst_n low, synchronous): clears region count, full-frame mode, output valid;
// the list memory itself is not cleared and is read only below the region count.
`default_nettype none

module dirty_region_tracker #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int MAX_REGIONS   = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire drt_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output drt_pkg::t_out_word      o_out_word
);

    import drt_pkg::*;

    localparam int XW = $clog2(SCREEN_WIDTH + 1);
    localparam int YW = $clog2(SCREEN_HEIGHT + 1);
    localparam int EW = 2 * XW + 2 * YW;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    localparam logic signed [CLAMP_W-1:0] SW_S = CLAMP_W'(SCREEN_WIDTH);
    localparam logic signed [CLAMP_W-1:0] SH_S = CLAMP_W'(SCREEN_HEIGHT);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_MARK,
        ST_REPLY,
        ST_FLUSH_ONE,
        ST_FLUSH_RD,
        ST_FLUSH_OUT
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_count;
    logic                       r_full;
    logic [CW-1:0]              r_idx;
    t_in_word                   r_in;
    logic signed [CLAMP_W-1:0]  r_x1, r_w1, r_y1, r_h1;
    logic                       r_out_valid;
    t_out_word                  r_out_word;

    logic                       out_space;
    logic                       out_load;
    logic                       in_accept;
    logic signed [CLAMP_W-1:0]  raw_x, raw_y, raw_w, raw_h;
    logic signed [CLAMP_W-1:0]  sum_x, sum_y, w2, h2;
    logic                       keep, covers, list_full;
    logic                       wr_en, rd_en;
    logic [EW-1:0]              wr_data, rd_data;
    logic [XW-1:0]              rd_left, rd_width;
    logic [YW-1:0]              rd_top, rd_height;
    logic [15:0]                ext_left, ext_top, ext_width, ext_height;
    logic                       flush_last;
    t_out_word                  n_out_word;

    assign out_space  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Load the output register from any answering state
    assign out_load = ((r_state == ST_REPLY) || (r_state == ST_FLUSH_ONE) ||
                       (r_state == ST_FLUSH_OUT)) && out_space;

    // Sign-extend the raw rectangle
    assign raw_x = CLAMP_W'(r_in.rect_left);
    assign raw_y = CLAMP_W'(r_in.rect_top);
    assign raw_w = CLAMP_W'(r_in.rect_width);
    assign raw_h = CLAMP_W'(r_in.rect_height);

    // Clip the far edges and classify the clamped rectangle
    assign sum_x     = r_x1 + r_w1;
    assign sum_y     = r_y1 + r_h1;
    assign w2        = (sum_x > SW_S) ? (SW_S - r_x1) : r_w1;
    assign h2        = (sum_y > SH_S) ? (SH_S - r_y1) : r_h1;
    assign keep      = (w2 > 0) && (h2 > 0);
    assign covers    = (w2 >= SW_S) && (h2 >= SH_S);
    assign list_full = (r_count >= CW'(MAX_REGIONS));

    // Append a kept rectangle to the list
    assign wr_en   = (r_state == ST_MARK) && !r_full && keep && !covers && !list_full;
    assign wr_data = {r_x1[XW-1:0], r_y1[YW-1:0], w2[XW-1:0], h2[YW-1:0]};
    assign rd_en   = (r_state == ST_FLUSH_RD);

    drt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_REGIONS),
        .AW    (AW)
    ) u_list (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // Unpack a stored region and fit it to the result fields
    assign {rd_left, rd_top, rd_width, rd_height} = rd_data;
    assign ext_left   = 16'(rd_left);
    assign ext_top    = 16'(rd_top);
    assign ext_width  = 16'(rd_width);
    assign ext_height = 16'(rd_height);
    assign flush_last = ((r_idx + CW'(1)) == r_count);

    // Build the result word for the current state
    always_comb begin
        n_out_word      = '0;
        n_out_word.last = 1'b1;
        case (r_state)
            ST_REPLY: begin
                n_out_word.pending = r_full || (r_count != '0);
            end
            ST_FLUSH_ONE: begin
                n_out_word.full_frame = r_full;
            end
            ST_FLUSH_OUT: begin
                n_out_word.region_valid = 1'b1;
                n_out_word.out_left     = ext_left[8:0];
                n_out_word.out_top      = ext_top[7:0];
                n_out_word.out_width    = ext_width[8:0];
                n_out_word.out_height   = ext_height[7:0];
                n_out_word.last         = flush_last;
            end
            default: begin
                n_out_word = '0;
            end
        endcase
    end

    // Sequence the items and hold the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_full      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result or drop a taken one
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_in <= i_in_word;
                        case (i_in_word.kind)
                            KIND_MARK: begin
                                r_state <= ST_CLAMP;
                            end
                            KIND_FULL: begin
                                r_full  <= 1'b1;
                                r_count <= '0;
                                r_state <= ST_REPLY;
                            end
                            KIND_CLEAR: begin
                                r_full  <= 1'b0;
                                r_count <= '0;
                                r_state <= ST_REPLY;
                            end
                            KIND_FLUSH: begin
                                r_idx <= '0;
                                if (r_full || (r_count == '0)) begin
                                    r_state <= ST_FLUSH_ONE;
                                end else begin
                                    r_state <= ST_FLUSH_RD;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CLAMP: begin
                    // clip the near edges at zero
                    r_x1    <= (raw_x < 0) ? '0 : raw_x;
                    r_w1    <= (raw_x < 0) ? (raw_w + raw_x) : raw_w;
                    r_y1    <= (raw_y < 0) ? '0 : raw_y;
                    r_h1    <= (raw_y < 0) ? (raw_h + raw_y) : raw_h;
                    r_state <= ST_MARK;
                end
                ST_MARK: begin
                    if (!r_full && keep) begin
                        if (covers || list_full) begin
                            r_full  <= 1'b1;
                            r_count <= '0;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    r_state <= ST_REPLY;
                end
                ST_REPLY: begin
                    if (out_space) begin
                        r_out_word  <= n_out_word;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_FLUSH_ONE: begin
                    if (out_space) begin
                        r_out_word  <= n_out_word;
                        r_full      <= 1'b0;
                        r_count     <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_FLUSH_RD: begin
                    r_state <= ST_FLUSH_OUT;
                end
                ST_FLUSH_OUT: begin
                    if (out_space) begin
                        r_out_word  <= n_out_word;
                        if (flush_last) begin
                            r_full  <= 1'b0;
                            r_count <= '0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= ST_FLUSH_RD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: hw/rtl/drt_checker.sv
`default_nettype none

module drt_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire drt_pkg::t_in_word  i_in_word,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire drt_pkg::t_out_word i_out_word
);

    import drt_pkg::*;

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_word)))
        else $error("result word dropped or changed while stalled");

    // One item at a time: the cycle after an accept the input is stalled
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_stall) |=> i_in_stall)
        else $error("input accepted while an item is in work");

    // A result never carries a region and full frame together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_word.full_frame && i_out_word.region_valid))
        else $error("full frame and region in one result");

    // Flush results report nothing pending
    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_word.full_frame || i_out_word.region_valid))
            |-> !i_out_word.pending)
        else $error("flush result shows pending");

    // A result that carries no region always closes its item
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_word.region_valid) |-> i_out_word.last)
        else $error("single result without last");

endmodule

bind dirty_region_tracker drt_checker u_drt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_word  (o_out_word)
);

`default_nettype wire

FILE: tb/tb_dirty_region_tracker.sv
`default_nettype none

module tb_dirty_region_tracker;

    import drt_pkg::*;

    localparam int SCR_W       = 320;
    localparam int SCR_H       = 240;
    localparam int LIST_DEPTH  = 8;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  in_word = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_word o_out_word;

    dirty_region_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    // Words waiting to be offered and results still owed by the block
    t_in_word  word_q[$];
    t_out_word owed_q[$];

    // Shadow of the tracker state
    logic [8:0] sh_left   [LIST_DEPTH];
    logic [7:0] sh_top    [LIST_DEPTH];
    logic [8:0] sh_width  [LIST_DEPTH];
    logic [7:0] sh_height [LIST_DEPTH];
    int         sh_count = 0;
    bit         sh_full = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int quiet_cnt = 0;
    int n_queued = 0;
    int n_in = 0;
    int n_out = 0;
    int errors = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Clamp a mark to the screen and update the shadow list
    task automatic shadow_mark(input t_in_word w);
        int x, y, wd, ht;
        x  = $signed(w.rect_left);
        y  = $signed(w.rect_top);
        wd = $signed(w.rect_width);
        ht = $signed(w.rect_height);
        if (sh_full) return;
        if (x < 0) begin
            wd = wd + x;
            x  = 0;
        end
        if (y < 0) begin
            ht = ht + y;
            y  = 0;
        end
        if (x + wd > SCR_W) wd = SCR_W - x;
        if (y + ht > SCR_H) ht = SCR_H - y;
        if (wd <= 0 || ht <= 0) return;
        if ((wd >= SCR_W && ht >= SCR_H) || sh_count >= LIST_DEPTH) begin
            sh_full  = 1'b1;
            sh_count = 0;
            return;
        end
        sh_left[sh_count]   = x[8:0];
        sh_top[sh_count]    = y[7:0];
        sh_width[sh_count]  = wd[8:0];
        sh_height[sh_count] = ht[7:0];
        sh_count++;
    endtask

    // Work out the result words one accepted input word causes
    task automatic predict_regions(input t_in_word w);
        t_out_word r;
        r = '0;
        if (w.kind == KIND_FLUSH) begin
            if (sh_full) begin
                r.full_frame = 1'b1;
                r.last       = 1'b1;
                owed_q.push_back(r);
            end else if (sh_count == 0) begin
                r.last = 1'b1;
                owed_q.push_back(r);
            end else begin
                for (int i = 0; i < sh_count; i++) begin
                    r              = '0;
                    r.region_valid = 1'b1;
                    r.out_left     = sh_left[i];
                    r.out_top      = sh_top[i];
                    r.out_width    = sh_width[i];
                    r.out_height   = sh_height[i];
                    r.last         = (i == sh_count - 1);
                    owed_q.push_back(r);
                end
            end
            sh_full  = 1'b0;
            sh_count = 0;
        end else begin
            case (w.kind)
                KIND_MARK: shadow_mark(w);
                KIND_FULL: begin
                    sh_full  = 1'b1;
                    sh_count = 0;
                end
                default: begin
                    sh_full  = 1'b0;
                    sh_count = 0;
                end
            endcase
            r.pending = sh_full || (sh_count > 0);
            r.last    = 1'b1;
            owed_q.push_back(r);
        end
    endtask

    function automatic t_in_word make_word(t_kind k, int l, int t, int w, int h);
        t_in_word v;
        v.kind        = k;
        v.rect_left   = 16'(l);
        v.rect_top    = 16'(t);
        v.rect_width  = 16'(w);
        v.rect_height = 16'(h);
        return v;
    endfunction

    function automatic t_in_word rand_word(t_kind k);
        return make_word(k, $urandom, $urandom, $urandom, $urandom);
    endfunction

    // Mostly near-screen rectangles, some whole-screen, some raw noise
    function automatic t_in_word rand_mark();
        int sel, l, t;
        sel = $urandom_range(15);
        if (sel == 0) return rand_word(KIND_MARK);
        if (sel == 1) begin
            l = -int'($urandom_range(20));
            t = -int'($urandom_range(20));
            return make_word(KIND_MARK, l, t, 340 + $urandom_range(100),
                             260 + $urandom_range(100));
        end
        return make_word(KIND_MARK, int'($urandom_range(399)) - 40,
                         int'($urandom_range(319)) - 40,
                         int'($urandom_range(208)) - 8,
                         int'($urandom_range(158)) - 8);
    endfunction

    task automatic queue_word(input t_in_word w);
        word_q.push_back(w);
        n_queued++;
    endtask

    // A run of marks, now and then a full-frame or clear, usually closed by a flush
    task automatic queue_sequence();
        int n;
        n = $urandom_range(11);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(11))
                0:       queue_word(rand_word(KIND_FULL));
                1:       queue_word(rand_word(KIND_CLEAR));
                default: queue_word(rand_mark());
            endcase
        end
        if ($urandom_range(9) != 0) queue_word(rand_word(KIND_FLUSH));
    endtask

    // Hold the sender until every owed result has come back
    task automatic wait_drained();
        while (word_q.size() != 0 || in_valid || owed_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (n_queued < target) begin
            if ($urandom_range(7) == 0)
                queue_word(rand_word(t_kind'($urandom_range(3))));
            else
                queue_sequence();
        end
        wait_drained();
    endtask

    // Driver: offer the next word once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) begin
                predict_regions(in_word);
                n_in++;
            end
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_word  <= word_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each taken result word and drive the output stall
    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_out++;
                if (owed_q.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_out_word);
                    errors++;
                end else begin
                    e = owed_q.pop_front();
                    if (o_out_word.full_frame   !== e.full_frame   ||
                        o_out_word.region_valid !== e.region_valid ||
                        o_out_word.out_left     !== e.out_left     ||
                        o_out_word.out_top      !== e.out_top      ||
                        o_out_word.out_width    !== e.out_width    ||
                        o_out_word.out_height   !== e.out_height   ||
                        o_out_word.pending      !== e.pending      ||
                        o_out_word.last         !== e.last) begin
                        $display("%0t: expected ff=%0d rv=%0d l=%0d t=%0d w=%0d h=%0d p=%0d last=%0d",
                                 $time, e.full_frame, e.region_valid, e.out_left, e.out_top,
                                 e.out_width, e.out_height, e.pending, e.last);
                        $display("%0t: actual   ff=%0d rv=%0d l=%0d t=%0d w=%0d h=%0d p=%0d last=%0d",
                                 $time, o_out_word.full_frame, o_out_word.region_valid,
                                 o_out_word.out_left, o_out_word.out_top, o_out_word.out_width,
                                 o_out_word.out_height, o_out_word.pending, o_out_word.last);
                        errors++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Count cycles with work outstanding but no word moving
    always @(posedge i_clk) begin
        if ((word_q.size() != 0 || owed_q.size() != 0 || in_valid) &&
            !(in_valid && !o_in_stall) && !(o_out_valid && !out_stall))
            quiet_cnt <= quiet_cnt + 1;
        else
            quiet_cnt <= 0;
    end

    initial begin
        wait (quiet_cnt >= QUIET_LIMIT);
        $display("%0t: timeout, no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty flush, clamping at every edge, drops, whole screen,
        // marks while full, list overflow, full-frame and clear words
        queue_word(rand_word(KIND_FLUSH));
        queue_word(make_word(KIND_MARK, 10, 20, 30, 40));
        queue_word(make_word(KIND_MARK, -5, -7, 10, 12));
        queue_word(make_word(KIND_MARK, 300, 230, 100, 100));
        queue_word(make_word(KIND_MARK, 50, 50, -3, 10));
        queue_word(make_word(KIND_MARK, 32767, 32767, 32767, 32767));
        queue_word(make_word(KIND_MARK, -32768, -32768, -32768, -32768));
        queue_word(make_word(KIND_MARK, -32768, -32768, 32767, 32767));
        queue_word(make_word(KIND_MARK, 319, 239, 1, 1));
        queue_word(rand_word(KIND_FLUSH));
        queue_word(make_word(KIND_MARK, -10, -10, 400, 400));
        queue_word(make_word(KIND_MARK, 1, 1, 5, 5));
        queue_word(rand_word(KIND_FLUSH));
        for (int i = 0; i < 9; i++)
            queue_word(make_word(KIND_MARK, i * 30, i * 20, 25, 15));
        queue_word(rand_word(KIND_FLUSH));
        queue_word(rand_word(KIND_FULL));
        queue_word(rand_word(KIND_CLEAR));
        queue_word(rand_word(KIND_FLUSH));
        wait_drained();

        // Random phases under different idling
        run_phase(0, 0, 120);
        run_phase(82, 0, 200);
        run_phase(0, 82, 280);
        run_phase(29, 29, 360);

        // Long output hold-off while marks keep coming, so the input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 24; i++)
            queue_word(rand_mark());
        run_phase(0, 0, 412);

        repeat (20) @(negedge i_clk);
        if (owed_q.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, owed_q.size());
            errors++;
        end
        $display("Drove %0d input words and checked %0d result words", n_in, n_out);
        $display("Phases: directed, unthrottled, sender idle, receiver stall, both, output hold");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
